/* hdl/fvd_pkg.sv */
package fvd_pkg;

	// Input mode codes.
	typedef enum logic [1:0] {
		MODE_NEXT   = 2'd0,
		MODE_FIRST  = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	// Result kinds.
	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_TRI    = 1'b1;

	// Width of the reported index fields.
	localparam int unsigned OUT_IDX_BITS = 12;
	localparam int unsigned OUT_KEY_BITS = 16;

endpackage

/* hdl/fvd_ram.sv */
module fvd_ram #(
	parameter int unsigned ADDR_BITS = 13,
	parameter int unsigned DATA_BITS = 61
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
	logic [DATA_BITS-1:0] rdata_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/fan_triangulate_vertex_dedup_core.sv */
// Fan triangulation with vertex deduplication through a linear-probing hash table.
// Corners that produce no triangle are accepted straight from idle. A fan corner is accepted,
// then each of its three lookups takes a probe and a check step, and the triangle word is
// registered last. Each collision adds another probe and check step, and a stalled output
// word holds the sequencer in place. Reset, and every clear word, start a sweep of all
// 2*TABLE_DEPTH hash slots (8192 at the default depth) during which no input word is
// accepted.
module fan_triangulate_vertex_dedup_core
	import fvd_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 4096,
	parameter int unsigned KEY_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [15:0] vertex_key,
	input  logic [15:0] uv_key,
	input  logic [15:0] normal_key,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [15:0] new_vertex_key,
	output logic [15:0] new_uv_key,
	output logic [15:0] new_normal_key,
	output logic [11:0] new_index,
	output logic [11:0] tri_first,
	output logic [11:0] tri_second,
	output logic [11:0] tri_third,
	output logic        table_full,
	output logic        last
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned HW = IW + 1;
	localparam int unsigned CW = IW + 1;
	localparam int unsigned KW = 3 * KEY_BITS;
	localparam int unsigned EW = 1 + KW + IW;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_TRI
	} state_t;

	// XOR fold of a packed corner onto the hash address.
	function automatic logic [HW-1:0] hash_key(input logic [KW-1:0] k);
		logic [HW-1:0] h;
		h = '0;
		for (int i = 0; i < KW; i++) begin
			h[i % HW] = h[i % HW] ^ k[i];
		end
		return h;
	endfunction

	function automatic logic [KEY_BITS-1:0] key_in(input logic [15:0] k);
		logic [KEY_BITS+15:0] t;
		t = {{KEY_BITS{1'b0}}, k};
		return t[KEY_BITS-1:0];
	endfunction

	function automatic logic [15:0] key_out(input logic [KEY_BITS-1:0] k);
		logic [KEY_BITS+15:0] t;
		t = {16'd0, k};
		return t[15:0];
	endfunction

	function automatic logic [11:0] idx_out(input logic [IW-1:0] k);
		logic [IW+11:0] t;
		t = {12'd0, k};
		return t[11:0];
	endfunction

	state_t          state_q;
	logic [HW-1:0]   clr_q;
	logic [HW-1:0]   addr_q;
	logic [CW-1:0]   count_q;
	logic [1:0]      seen_q;
	logic [1:0]      sel_q;
	logic            full_q;
	logic [KW-1:0]   anchor_q;
	logic [KW-1:0]   prev_q;
	logic [KW-1:0]   cur_q;
	logic [IW-1:0]   idx_q [3];

	logic            ovalid_q;
	logic            kind_q;
	logic [15:0]     nv_q;
	logic [15:0]     nu_q;
	logic [15:0]     nn_q;
	logic [11:0]     nidx_q;
	logic [11:0]     t0_q;
	logic [11:0]     t1_q;
	logic [11:0]     t2_q;
	logic            full_out_q;
	logic            last_q;

	logic [KW-1:0]   in_corner;
	logic [KW-1:0]   probe_key;
	logic [EW-1:0]   rd_data;
	logic            rd_valid;
	logic [KW-1:0]   rd_key;
	logic [IW-1:0]   rd_idx;
	logic            hit;
	logic            emit_ok;
	logic            room;
	logic            do_insert;
	logic            do_tri;
	logic            ram_we;
	logic [HW-1:0]   ram_waddr;
	logic [EW-1:0]   ram_wdata;

	assign in_corner = {key_in(vertex_key), key_in(uv_key), key_in(normal_key)};

	// Key of the corner being resolved.
	always_comb begin
		case (sel_q)
			2'd0:    probe_key = anchor_q;
			2'd1:    probe_key = prev_q;
			default: probe_key = cur_q;
		endcase
	end

	assign rd_valid  = rd_data[EW-1];
	assign rd_key    = rd_data[EW-2:IW];
	assign rd_idx    = rd_data[IW-1:0];
	assign hit       = rd_valid && (rd_key == probe_key);
	assign emit_ok   = !ovalid_q || !out_stall;
	assign room      = (count_q != CW'(TABLE_DEPTH));
	// A new corner is stored and reported in the same cycle; the triangle word follows.
	assign do_insert = (state_q == ST_CHECK) && !rd_valid && room && emit_ok;
	assign do_tri    = (state_q == ST_TRI) && emit_ok;

	// Write port: clearing sweep or insertion of a new corner.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {1'b1, probe_key, count_q[IW-1:0]};
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (do_insert) begin
			ram_we = 1'b1;
		end
	end

	fvd_ram #(
		.ADDR_BITS(HW),
		.DATA_BITS(EW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (state_q == ST_PROBE),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// Sequencer and output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			count_q  <= '0;
			seen_q   <= '0;
			sel_q    <= '0;
			full_q   <= 1'b0;
			ovalid_q <= 1'b0;
			anchor_q <= '0;
			prev_q   <= '0;
		end else begin
			if (do_insert || do_tri) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {HW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						unique case (mode_t'(mode))
							MODE_UNUSED: begin
							end
							MODE_CLEAR: begin
								count_q <= '0;
								seen_q  <= '0;
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							MODE_FIRST, MODE_NEXT: begin
								if (mode_t'(mode) == MODE_FIRST || seen_q == 2'd0) begin
									anchor_q <= in_corner;
									seen_q   <= 2'd1;
								end else if (seen_q == 2'd1) begin
									prev_q <= in_corner;
									seen_q <= 2'd2;
								end else begin
									cur_q   <= in_corner;
									sel_q   <= 2'd0;
									full_q  <= 1'b0;
									addr_q  <= hash_key(anchor_q);
									state_q <= ST_PROBE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_PROBE: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (rd_valid && !hit) begin
						// Occupied by another corner: step to the next slot.
						addr_q  <= addr_q + 1'b1;
						state_q <= ST_PROBE;
					end else if (hit || !room || emit_ok) begin
						if (hit) begin
							idx_q[sel_q] <= rd_idx;
						end else if (!room) begin
							full_q       <= 1'b1;
							idx_q[sel_q] <= '0;
						end else begin
							idx_q[sel_q] <= count_q[IW-1:0];
							count_q      <= count_q + 1'b1;
							kind_q       <= KIND_VERTEX;
							nv_q         <= key_out(probe_key[KW-1:2*KEY_BITS]);
							nu_q         <= key_out(probe_key[2*KEY_BITS-1:KEY_BITS]);
							nn_q         <= key_out(probe_key[KEY_BITS-1:0]);
							nidx_q       <= idx_out(count_q[IW-1:0]);
							t0_q         <= '0;
							t1_q         <= '0;
							t2_q         <= '0;
							full_out_q   <= 1'b0;
							last_q       <= 1'b0;
						end
						// Move on to the next corner of the triangle.
						if (sel_q == 2'd2) begin
							state_q <= ST_TRI;
						end else begin
							sel_q   <= sel_q + 2'd1;
							addr_q  <= hash_key((sel_q == 2'd0) ? prev_q : cur_q);
							state_q <= ST_PROBE;
						end
					end
				end
				ST_TRI: begin
					if (emit_ok) begin
						kind_q     <= KIND_TRI;
						nv_q       <= '0;
						nu_q       <= '0;
						nn_q       <= '0;
						nidx_q     <= '0;
						t0_q       <= full_q ? 12'd0 : idx_out(idx_q[0]);
						t1_q       <= full_q ? 12'd0 : idx_out(idx_q[1]);
						t2_q       <= full_q ? 12'd0 : idx_out(idx_q[2]);
						full_out_q <= full_q;
						last_q     <= 1'b1;
						prev_q     <= cur_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = ovalid_q;
	assign kind           = kind_q;
	assign new_vertex_key = nv_q;
	assign new_uv_key     = nu_q;
	assign new_normal_key = nn_q;
	assign new_index      = nidx_q;
	assign tri_first      = t0_q;
	assign tri_second     = t1_q;
	assign tri_third      = t2_q;
	assign table_full     = full_out_q;
	assign last           = last_q;

endmodule

/* sim/tb_fan_triangulate_vertex_dedup_core.sv */
`timescale 1ns / 100ps

module tb_fan_triangulate_vertex_dedup_core;
	import fvd_pkg::*;

	localparam int unsigned DEPTH = 4096;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned RANDOM_WORDS = 480;

	typedef struct packed {
		logic        kind;
		logic [15:0] vkey;
		logic [15:0] ukey;
		logic [15:0] nkey;
		logic [11:0] nidx;
		logic [11:0] first;
		logic [11:0] second;
		logic [11:0] third;
		logic        full;
		logic        last;
	} record_t;

	typedef struct {
		mode_t       m;
		logic [15:0] v;
		logic [15:0] u;
		logic [15:0] n;
		bit          typed;
		logic [11:0] first;
		logic [11:0] second;
		logic [11:0] third;
		logic        full;
	} corner_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = MODE_UNUSED;
	logic [15:0] vertex_key = '0;
	logic [15:0] uv_key = '0;
	logic [15:0] normal_key = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic kind;
	logic [15:0] new_vertex_key, new_uv_key, new_normal_key;
	logic [11:0] new_index, tri_first, tri_second, tri_third;
	logic table_full, last;

	// Model of the block.
	int unsigned slot_of[logic [47:0]];
	int unsigned stored_count;
	logic [47:0] anchor, prev_corner;
	int unsigned face_corners;
	record_t pending_records[$];

	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned words_sent = 0;
	int unsigned records_seen = 0;
	int unsigned triangles_seen = 0;
	int unsigned full_seen = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	bit hold_phase = 1'b0;
	bit hold_done = 1'b0;
	int unsigned hold_count = 0;

	corner_row_t directed[] = '{
		'{MODE_UNUSED, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 0, 0},
		'{MODE_FIRST,  16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 0},
		'{MODE_NEXT,   16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 0, 0},
		'{MODE_NEXT,   16'h0001, 16'h0002, 16'h0003, 1, 0, 1, 2, 0},
		'{MODE_NEXT,   16'h0000, 16'h0000, 16'h0000, 1, 0, 2, 0, 0},
		'{MODE_CLEAR,  16'h1234, 16'h5678, 16'h9abc, 0, 0, 0, 0, 0},
		'{MODE_NEXT,   16'h0005, 16'h0005, 16'h0005, 0, 0, 0, 0, 0},
		'{MODE_NEXT,   16'h0006, 16'h0006, 16'h0006, 0, 0, 0, 0, 0},
		'{MODE_UNUSED, 16'h0007, 16'h0007, 16'h0007, 0, 0, 0, 0, 0},
		'{MODE_NEXT,   16'h0005, 16'h0005, 16'h0005, 1, 0, 1, 0, 0},
		'{MODE_FIRST,  16'ha5a5, 16'h5a5a, 16'hffff, 0, 0, 0, 0, 0},
		'{MODE_NEXT,   16'h0000, 16'hffff, 16'h0000, 0, 0, 0, 0, 0},
		'{MODE_NEXT,   16'hffff, 16'h0000, 16'hffff, 0, 0, 0, 0, 0},
		'{MODE_NEXT,   16'h0001, 16'h0001, 16'h0001, 0, 0, 0, 0, 0},
		'{MODE_NEXT,   16'h5a5a, 16'ha5a5, 16'h0000, 0, 0, 0, 0, 0}
	};

	fan_triangulate_vertex_dedup_core dut (.*);

	always #5 clk = ~clk;

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h (record %0d)", what, got, want, records_seen);
	endtask

	// Looks a corner up in the dedup table, inserting it if there is room.
	task automatic lookup_corner(input logic [47:0] c, output logic [11:0] idx, inout bit ok);
		record_t r;
		if (slot_of.exists(c)) begin
			idx = slot_of[c][11:0];
		end else if (stored_count >= DEPTH) begin
			idx = '0;
			ok = 1'b0;
		end else begin
			slot_of[c] = stored_count;
			idx = stored_count[11:0];
			r = '0;
			r.kind = KIND_VERTEX;
			r.vkey = c[47:32];
			r.ukey = c[31:16];
			r.nkey = c[15:0];
			r.nidx = idx;
			pending_records = {pending_records, r};
			stored_count++;
		end
	endtask

	// Advances the model by one accepted corner word.
	task automatic predict_corner(input logic [1:0] m, input logic [47:0] c);
		logic [11:0] i0, i1, i2;
		bit ok;
		record_t t;
		ok = 1'b1;
		if (m == MODE_UNUSED) begin
			return;
		end
		if (m == MODE_CLEAR) begin
			slot_of.delete();
			stored_count = 0;
			face_corners = 0;
			return;
		end
		if (m == MODE_FIRST || face_corners == 0) begin
			anchor = c;
			face_corners = 1;
			return;
		end
		if (face_corners == 1) begin
			prev_corner = c;
			face_corners = 2;
			return;
		end
		lookup_corner(anchor, i0, ok);
		lookup_corner(prev_corner, i1, ok);
		lookup_corner(c, i2, ok);
		prev_corner = c;
		t = '0;
		t.kind = KIND_TRI;
		t.last = 1'b1;
		if (ok) begin
			t.first = i0;
			t.second = i1;
			t.third = i2;
		end else begin
			t.full = 1'b1;
		end
		pending_records = {pending_records, t};
	endtask

	// Offers one word and waits until the block takes it.
	task automatic send_word(input logic [1:0] m, input logic [15:0] v, input logic [15:0] u,
			input logic [15:0] n);
		if (tx_idle_en && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 23)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		vertex_key <= v;
		uv_key <= u;
		normal_key <= n;
		do
			@(posedge clk);
		while (in_stall);
		predict_corner(m, {v, u, n});
		words_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
	endtask

	// Receiver side: random stalls, plus one long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else if (hold_phase && !hold_done) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
			if (hold_count >= HOLD_CYCLES)
				hold_done <= 1'b1;
		end else begin
			out_stall <= rx_idle_en && ($urandom_range(99) < 23);
		end
	end

	// Compares every accepted result word with the oldest expectation.
	always @(posedge clk) begin
		record_t w;
		if (arst_n && out_valid && !out_stall) begin
			records_seen++;
			if (pending_records.size() == 0) begin
				report("unexpected word, kind", 16'(kind), 16'd0);
			end else begin
				w = pending_records.pop_front();
				if (kind == KIND_TRI) triangles_seen++;
				if (table_full) full_seen++;
				if (kind !== w.kind) report("kind", 16'(kind), 16'(w.kind));
				if (new_vertex_key !== w.vkey) report("new_vertex_key", new_vertex_key, w.vkey);
				if (new_uv_key !== w.ukey) report("new_uv_key", new_uv_key, w.ukey);
				if (new_normal_key !== w.nkey) report("new_normal_key", new_normal_key, w.nkey);
				if (new_index !== w.nidx) report("new_index", 16'(new_index), 16'(w.nidx));
				if (tri_first !== w.first) report("tri_first", 16'(tri_first), 16'(w.first));
				if (tri_second !== w.second)
					report("tri_second", 16'(tri_second), 16'(w.second));
				if (tri_third !== w.third) report("tri_third", 16'(tri_third), 16'(w.third));
				if (table_full !== w.full)
					report("table_full", 16'(table_full), 16'(w.full));
				if (last !== w.last) report("last", 16'(last), 16'(w.last));
			end
		end
	end

	// Stimulus.
	initial begin
		logic [15:0] pool_v[8], pool_u[8], pool_n[8];
		logic [15:0] rv, ru, rn;
		int unsigned face_len, sent, k, pick;
		stored_count = 0;
		face_corners = 0;
		anchor = '0;
		prev_corner = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners; typed rows override the model's triangle indices and full flag.
		foreach (directed[i]) begin
			send_word(directed[i].m, directed[i].v, directed[i].u, directed[i].n);
			if (directed[i].typed) begin
				pending_records[$].first = directed[i].first;
				pending_records[$].second = directed[i].second;
				pending_records[$].third = directed[i].third;
				pending_records[$].full = directed[i].full;
			end
		end
		wait_drained();

		// Random faces with keys mostly from a small pool so that dedup hits occur.
		foreach (pool_v[i]) begin
			pool_v[i] = (i == 0) ? 16'h0 : (i == 1) ? 16'hffff : 16'($urandom);
			pool_u[i] = (i == 0) ? 16'hffff : 16'($urandom);
			pool_n[i] = (i == 1) ? 16'h0 : 16'($urandom);
		end
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			tx_idle_en = !(sent >= 100 && sent < 200);
			rx_idle_en = tx_idle_en;
			hold_phase = (sent >= 250);
			if (sent >= 350 && sent < 360)
				wait_drained();
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_word(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				sent++;
			end else if (pick < 10) begin
				send_word(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
				sent++;
			end else begin
				face_len = $urandom_range(8, 3);
				for (k = 0; k < face_len; k++) begin
					if ($urandom_range(3) == 0) begin
						rv = 16'($urandom);
						ru = 16'($urandom);
						rn = 16'($urandom);
					end else begin
						rv = pool_v[$urandom_range(7)];
						ru = pool_u[$urandom_range(7)];
						rn = pool_n[$urandom_range(7)];
					end
					send_word((k == 0 && $urandom_range(3) != 0) ? MODE_FIRST : MODE_NEXT,
						rv, ru, rn);
					sent++;
				end
			end
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		wait_drained();
		repeat (50) @(posedge clk);

		$display("Sent %0d corner words; checked %0d result words, %0d triangles, %0d flagged full.",
			words_sent, records_seen, triangles_seen, full_seen);
		$display("Covered dedup hits, clears, unused modes, a full drain and a long output hold-off.");
		if (errors == 0 && pending_records.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_records.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
